// File: rtl/sprite_frame_sequencer_with_fade_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sprite frame sequencer
// Shared property wrappers, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef SPRITE_FRAME_SEQUENCER_WITH_FADE_MACROS_SVH
`define SPRITE_FRAME_SEQUENCER_WITH_FADE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SFS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfs assertion failed");

// Consequent must hold in the cycle after the antecedent
`define SFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfs assertion failed");

`endif

// File: rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Types, constants and codes shared by the sprite frame sequencer modules.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Frame table
  localparam int MAX_FRAMES = 16;
  localparam int SLOT_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W      = SLOT_W + 1;

  // Field widths
  localparam int TIME_W  = 16;
  localparam int TIMER_W = TIME_W + 1;
  localparam int ALPHA_W = 8;
  localparam int NUM_W   = ALPHA_W + TIME_W;

  // Opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration registers
  localparam int   REG_IDX_W       = 1;
  localparam int   PADDR_W         = REG_IDX_W + 2;
  localparam int   PDATA_W         = 32;
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_ZIGZAG      = 1'b1;
  localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = CNT_W'(1);

  // Command queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  typedef struct packed {
    logic               opcode;
    logic [TIME_W-1:0]  elapsed_time;
    logic [3:0]         load_slot;
    logic [TIME_W-1:0]  load_delay;
    logic [ALPHA_W-1:0] load_alpha_start;
    logic [ALPHA_W-1:0] load_alpha_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         shown_frame;
    logic               cycle_done;
    logic [ALPHA_W-1:0] fade_alpha;
    logic               fade_valid;
  } out_item_t;

  // Classified command held in the queue
  typedef struct packed {
    logic               is_tick;
    logic               load_ok;
    logic [TIME_W-1:0]  elapsed;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  delay;
    logic [ALPHA_W-1:0] alpha_start;
    logic [ALPHA_W-1:0] alpha_end;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] frame_count;
    logic             zigzag_mode;
  } cfg_t;

endpackage

// File: rtl/sprite_frame_sequencer_with_fade.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_with_fade
// Frame sequencer with alpha fade. Load items write one slot of a 16-entry
// frame table (delay, start alpha, end alpha); tick items advance the frame
// timer, step frames forward (wrapping, or ping-ponging in zigzag mode) and
// flag the end of each pass. Every item yields one result: the physical slot
// shown and, where start and end alpha differ, start + (end-start)*t/delay
// truncated. Items queue in a two-entry command buffer, so input is taken
// while the back end works or a result waits. A load passes through the
// evaluate and output states of the back end, a tick also through the advance
// state; a fading frame adds the product, divider start, serial divide steps
// and the wait for the divider's done flag. A result left unpopped holds
// the back end in its output state.
// frame_count lies at byte address 0, zigzag_mode at 4.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_with_fade (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  sfs_pkg::in_item_t             item,
  output logic                          empty,
  input  logic                          pop,
  output sfs_pkg::out_item_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfs_pkg::PADDR_W-1:0]   paddr,
  input  logic [sfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [sfs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import sfs_pkg::*;

  cfg_t             cfg;
  logic             q_empty;
  logic             q_pop;
  cmd_t             q_cmd;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_count <= FRAME_COUNT_RESET;
      cfg.zigzag_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_FRAME_COUNT: cfg.frame_count <= pwdata[CNT_W-1:0];
        REG_ZIGZAG:      cfg.zigzag_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_FRAME_COUNT: prdata = PDATA_W'(cfg.frame_count);
      REG_ZIGZAG:      prdata = PDATA_W'(cfg.zigzag_mode);
      default:         prdata = '0;
    endcase
  end

  sfs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd)
  );

  sfs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_cmd   (q_cmd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// File: rtl/sfs_front.sv
// ----------------------------------------------------------------------------
// sfs_front
// Accepts items, classifies them as tick or load and queues the commands.
// ----------------------------------------------------------------------------
module sfs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sfs_pkg::in_item_t item,
  output logic              q_empty,
  input  logic              q_pop,
  output sfs_pkg::cmd_t     q_cmd
);
  import sfs_pkg::*;

  cmd_t                cmd_mem [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] count;
  logic                do_push;
  logic                do_pop;
  cmd_t                cmd_in;

  // Classify the incoming item
  always_comb begin
    cmd_in             = '0;
    cmd_in.is_tick     = (item.opcode == OP_TICK);
    cmd_in.load_ok     = ({1'b0, item.load_slot} < 5'(MAX_FRAMES));
    cmd_in.elapsed     = item.elapsed_time;
    cmd_in.slot        = SLOT_W'(item.load_slot);
    cmd_in.delay       = item.load_delay;
    cmd_in.alpha_start = item.load_alpha_start;
    cmd_in.alpha_end   = item.load_alpha_end;
  end

  assign full    = (count == FQ_CNT_W'(FQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;
  assign q_cmd   = cmd_mem[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the command
  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

// File: rtl/sfs_div.sv
// ----------------------------------------------------------------------------
// sfs_div
// Serial restoring divider, one quotient bit a cycle, for the fade ratio.
// The quotient is known to fit in ALPHA_W bits (numerator below 2^8 * den).
// ----------------------------------------------------------------------------
module sfs_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sfs_pkg::NUM_W-1:0]  num,
  input  logic [sfs_pkg::TIME_W-1:0] den,
  output logic                       done,
  output logic [sfs_pkg::ALPHA_W-1:0] quo,
  output logic [sfs_pkg::TIME_W-1:0] rem
);
  import sfs_pkg::*;

  localparam int STEP_W = $clog2(ALPHA_W);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [TIME_W-1:0]   part;
  logic [ALPHA_W-1:0]  shift;
  logic [TIME_W:0]     trial;
  logic                fits;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {part, shift[ALPHA_W-1]};
  assign fits  = (trial >= {1'b0, den});
  assign quo   = shift;
  assign rem   = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      // Flag completion the cycle after the last quotient bit
      done <= busy && !start && (step == '0);
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(ALPHA_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Numerator low bits and quotient share the shift register
  always_ff @(posedge clk) begin
    if (start) begin
      part  <= num[NUM_W-1:ALPHA_W];
      shift <= num[ALPHA_W-1:0];
    end else if (busy) begin
      part  <= fits ? TIME_W'(trial - {1'b0, den}) : trial[TIME_W-1:0];
      shift <= {shift[ALPHA_W-2:0], fits};
    end
  end

endmodule

// File: rtl/sfs_back.sv
// ----------------------------------------------------------------------------
// sfs_back
// Carries out queued commands: table writes, frame timing and fade alpha,
// and holds the finished result in an output register.
// ----------------------------------------------------------------------------
`include "sprite_frame_sequencer_with_fade_macros.svh"

module sfs_back (
  input  logic               clk,
  input  logic               rst,
  input  sfs_pkg::cfg_t      cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  sfs_pkg::cmd_t      q_cmd,
  output logic               empty,
  input  logic               pop,
  output sfs_pkg::out_item_t result
);
  import sfs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADV   = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]          state;
  logic [SLOT_W-1:0]   cur;
  logic                backward;
  logic [TIMER_W-1:0]  timer;
  logic                tick_r;
  logic                done_r;
  logic                out_valid;

  // Frame table
  logic [TIME_W-1:0]   delay_mem  [MAX_FRAMES];
  logic [ALPHA_W-1:0]  astart_mem [MAX_FRAMES];
  logic [ALPHA_W-1:0]  aend_mem   [MAX_FRAMES];

  // Fade operands
  logic [SLOT_W-1:0]   p_r;
  logic [ALPHA_W-1:0]  a0_r;
  logic                up_r;
  logic                valid_r;
  logic [ALPHA_W-1:0]  diff_r;
  logic [TIME_W-1:0]   t_r;
  logic [TIME_W-1:0]   d_r;
  logic [NUM_W-1:0]    prod_r;
  logic [ALPHA_W-1:0]  q_r;
  logic                rem_nz;

  logic [CNT_W-1:0]    n;
  logic [CNT_W-1:0]    nm1;
  logic [SLOT_W-1:0]   cur_clamped;
  logic [SLOT_W-1:0]   phys;
  logic [TIMER_W:0]    sum;
  logic [TIME_W-1:0]   rd_delay;
  logic [ALPHA_W-1:0]  rd_a0;
  logic [ALPHA_W-1:0]  rd_a1;
  logic                out_free;
  logic                out_we;
  logic                div_done;
  logic [ALPHA_W-1:0]  div_quo;
  logic [TIME_W-1:0]   div_rem;
  logic [ALPHA_W-1:0]  alpha;

  // Effective frame count and clamped logical slot
  always_comb begin
    if (cfg.frame_count == '0) begin
      n = CNT_W'(1);
    end else if (cfg.frame_count > CNT_W'(MAX_FRAMES)) begin
      n = CNT_W'(MAX_FRAMES);
    end else begin
      n = cfg.frame_count;
    end
    nm1         = n - 1'b1;
    cur_clamped = ({1'b0, cur} > nm1) ? nm1[SLOT_W-1:0] : cur;
  end

  // Physical slot: mirror the table when running backward
  assign phys = backward ? SLOT_W'(nm1 - {1'b0, cur}) : cur;

  assign rd_delay = delay_mem[phys];
  assign rd_a0    = astart_mem[phys];
  assign rd_a1    = aend_mem[phys];

  // Saturating timer sum
  assign sum = {1'b0, timer} + (TIMER_W + 1)'(q_cmd.elapsed);

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || pop;
  assign out_we   = (state == S_OUT) && out_free;
  assign empty    = !out_valid;

  // Final fade value
  always_comb begin
    if (!valid_r) begin
      alpha = a0_r;
    end else if (up_r) begin
      alpha = a0_r + q_r;
    end else begin
      alpha = a0_r - q_r - ALPHA_W'(rem_nz);
    end
  end

  sfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .num   (prod_r),
    .den   (d_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      backward  <= 1'b0;
      timer     <= '0;
      tick_r    <= 1'b0;
      done_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Fill the output register, or drop the item once it is popped
      if (out_we) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur    <= cur_clamped;
            tick_r <= q_cmd.is_tick;
            done_r <= 1'b0;
            if (q_cmd.is_tick) begin
              timer <= sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
              state <= S_ADV;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_ADV: begin
          // Step to the next frame once the delay has run out
          if (timer >= {1'b0, rd_delay}) begin
            timer <= '0;
            if ({1'b0, cur} == nm1) begin
              done_r <= 1'b1;
              if (cfg.zigzag_mode) begin
                backward <= !backward;
                cur      <= (n >= CNT_W'(2)) ? SLOT_W'(1) : '0;
              end else begin
                cur <= '0;
              end
            end else begin
              cur <= cur + 1'b1;
            end
          end
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= ((rd_a0 == rd_a1) || (rd_delay == '0)) ? S_OUT : S_MUL;
        end
        S_MUL: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (q_pop && !q_cmd.is_tick && q_cmd.load_ok) begin
      delay_mem[q_cmd.slot]  <= q_cmd.delay;
      astart_mem[q_cmd.slot] <= q_cmd.alpha_start;
      aend_mem[q_cmd.slot]   <= q_cmd.alpha_end;
    end
  end

  // Fade operands, product and quotient
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      p_r     <= phys;
      a0_r    <= rd_a0;
      valid_r <= (rd_a0 != rd_a1);
      up_r    <= (rd_a0 <= rd_a1);
      diff_r  <= (rd_a0 <= rd_a1) ? rd_a1 - rd_a0 : rd_a0 - rd_a1;
      t_r     <= (timer > {1'b0, rd_delay}) ? rd_delay : timer[TIME_W-1:0];
      d_r     <= rd_delay;
      q_r     <= '0;
      rem_nz  <= 1'b0;
    end
    if (state == S_MUL) begin
      prod_r <= NUM_W'(diff_r) * NUM_W'(t_r);
    end
    if ((state == S_DIV) && div_done) begin
      q_r    <= div_quo;
      rem_nz <= (div_rem != '0);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_we) begin
      result.shown_frame <= 4'(p_r);
      result.cycle_done  <= done_r;
      result.fade_alpha  <= alpha;
      result.fade_valid  <= valid_r;
    end
  end

  `SFS_ASSERT_NEXT(a_take_leaves_idle, (state == S_IDLE) && !q_empty, state != S_IDLE)
  `SFS_ASSERT_SAME(a_div_done_in_wait, div_done, state == S_DIV)
  `SFS_ASSERT_SAME(a_load_never_done, out_we && !tick_r, !done_r)
  `SFS_ASSERT_SAME(a_slot_within_count, state == S_EVAL, {1'b0, cur} <= nm1)

endmodule
